FILE: rtl/core/smp_pkg.sv
package smp_pkg;

	localparam int IMAGE_SIZE  = 32;
	localparam int KERNEL_SIZE = 2;
	localparam int OUT_SIZE    = 16;
	localparam int CHANNELS    = 8;

	localparam int DATA_W     = 28;
	localparam int INT_BITS   = 10;
	localparam int FRAC_BITS  = DATA_W - INT_BITS;

	localparam int POOL_SPAN   = OUT_SIZE * KERNEL_SIZE;
	localparam int FRAME_SPAN  = (POOL_SPAN > IMAGE_SIZE) ? POOL_SPAN : IMAGE_SIZE;
	localparam int STORE_DEPTH = OUT_SIZE * CHANNELS;

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int POS_W = $clog2(FRAME_SPAN);
	localparam int K_W   = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;
	localparam int WIN_W = $clog2(OUT_SIZE + 1);
	localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             active;
		logic             first;
		logic             emit;
		logic             last;
	} tag_t;

endpackage

FILE: rtl/core/smp_ctr.sv
module smp_ctr (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	output smp_pkg::tag_t tag
);

	logic [smp_pkg::CH_W-1:0]  chan_q;
	logic [smp_pkg::POS_W-1:0] col_q;
	logic [smp_pkg::POS_W-1:0] row_q;
	logic [smp_pkg::K_W-1:0]   m_q;
	logic [smp_pkg::K_W-1:0]   l_q;
	logic [smp_pkg::WIN_W-1:0] j_q;
	logic [smp_pkg::WIN_W-1:0] i_q;

	logic chan_last, col_last, row_last, col_act, row_act, m_last, l_last;

	always_comb begin
		chan_last = chan_q == smp_pkg::CH_W'(smp_pkg::CHANNELS - 1);
		col_last  = col_q == smp_pkg::POS_W'(smp_pkg::FRAME_SPAN - 1);
		row_last  = row_q == smp_pkg::POS_W'(smp_pkg::FRAME_SPAN - 1);
		col_act   = {1'b0, col_q} < (smp_pkg::POS_W + 1)'(smp_pkg::POOL_SPAN);
		row_act   = {1'b0, row_q} < (smp_pkg::POS_W + 1)'(smp_pkg::POOL_SPAN);
		m_last    = m_q == smp_pkg::K_W'(smp_pkg::KERNEL_SIZE - 1);
		l_last    = l_q == smp_pkg::K_W'(smp_pkg::KERNEL_SIZE - 1);

		tag.active = col_act && row_act;
		tag.first  = (m_q == '0) && (l_q == '0);
		tag.emit   = m_last && l_last;
		tag.last   = (i_q == smp_pkg::WIN_W'(smp_pkg::OUT_SIZE - 1)) &&
		             (j_q == smp_pkg::WIN_W'(smp_pkg::OUT_SIZE - 1)) && chan_last;
		tag.idx    = smp_pkg::IDX_W'(int'(j_q) * smp_pkg::CHANNELS + int'(chan_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
			m_q    <= '0;
			l_q    <= '0;
			j_q    <= '0;
			i_q    <= '0;
		end else if (adv) begin
			if (!chan_last) begin
				chan_q <= chan_q + 1'b1;
			end else begin
				chan_q <= '0;
				if (col_last) begin
					col_q <= '0;
					m_q   <= '0;
					j_q   <= '0;
					if (row_last) begin
						row_q <= '0;
						l_q   <= '0;
						i_q   <= '0;
					end else begin
						row_q <= row_q + 1'b1;
						if (row_act) begin
							if (l_last) begin
								l_q <= '0;
								i_q <= i_q + 1'b1;
							end else begin
								l_q <= l_q + 1'b1;
							end
						end
					end
				end else begin
					col_q <= col_q + 1'b1;
					if (col_act) begin
						if (m_last) begin
							m_q <= '0;
							j_q <= j_q + 1'b1;
						end else begin
							m_q <= m_q + 1'b1;
						end
					end
				end
			end
		end
	end

endmodule

FILE: rtl/core/smp_store.sv
module smp_store (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rd_en,
	input  smp_pkg::tag_t  rd_tag,
	input  smp_pkg::data_t rd_sample,
	input  logic           adv_s1,
	output logic           valid_s1,
	output smp_pkg::tag_t  tag_s1,
	output smp_pkg::data_t result_s1
);

	smp_pkg::data_t mem [smp_pkg::STORE_DEPTH];

	smp_pkg::data_t rd_data_s1;
	smp_pkg::data_t sample_s1;

	logic                      fwd_vld_q;
	logic [smp_pkg::IDX_W-1:0] fwd_idx_q;
	smp_pkg::data_t            fwd_data_q;

	smp_pkg::data_t old_val;
	logic           wr_en;

	// last write bypasses the read that happened on the same edge
	always_comb begin
		old_val   = (fwd_vld_q && fwd_idx_q == tag_s1.idx) ? fwd_data_q : rd_data_s1;
		result_s1 = (tag_s1.first || sample_s1 > old_val) ? sample_s1 : old_val;
		wr_en     = adv_s1 && tag_s1.active;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tag_s1.idx] <= result_s1;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_tag.idx];
			sample_s1  <= rd_sample;
			tag_s1     <= rd_tag;
		end
		if (wr_en) begin
			fwd_idx_q  <= tag_s1.idx;
			fwd_data_q <= result_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (wr_en) begin
				fwd_vld_q <= 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/stream_max_pool_2d_top.sv
// Streaming 2-D max pooling: signed 28-bit activations (18 fraction bits) enter
// in raster order with channels innermost, one transfer per cycle sustained;
// each window's maximum is registered in the s1 stage, then in the output
// register before leaving on pooled; frame_end marks a frame's last result.
// The rate is set by one read and one write a cycle on the running-maximum
// row store (one entry per pooled column and channel), with the last write
// forwarded to the following read; input stalls only while a result sits
// unaccepted in the output register. Trailing rows and columns are consumed
// without producing results.
module stream_max_pool_2d_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           sample_valid,
	output logic           sample_ready,
	input  smp_pkg::data_t sample,
	output logic           pooled_valid,
	input  logic           pooled_ready,
	output smp_pkg::data_t pooled,
	output logic           frame_end
);

	smp_pkg::tag_t  cur_tag;
	smp_pkg::tag_t  tag_s1;
	smp_pkg::data_t result_s1;
	logic           valid_s1;
	logic           emit_s1;
	logic           adv_s1;
	logic           in_fire;

	logic           out_vld_q;
	smp_pkg::data_t pooled_q;
	logic           frame_end_q;

	always_comb begin
		emit_s1      = valid_s1 && tag_s1.active && tag_s1.emit;
		adv_s1       = valid_s1 && (!emit_s1 || !out_vld_q || pooled_ready);
		sample_ready = !valid_s1 || adv_s1;
		in_fire      = sample_valid && sample_ready;
	end

	smp_ctr u_ctr (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (in_fire),
		.tag    (cur_tag)
	);

	smp_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (in_fire),
		.rd_tag    (cur_tag),
		.rd_sample (sample),
		.adv_s1    (adv_s1),
		.valid_s1  (valid_s1),
		.tag_s1    (tag_s1),
		.result_s1 (result_s1)
	);

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			pooled_q    <= result_s1;
			frame_end_q <= tag_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1 && emit_s1) begin
			out_vld_q <= 1'b1;
		end else if (pooled_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign pooled_valid = out_vld_q;
	assign pooled       = pooled_q;
	assign frame_end    = frame_end_q;

`ifndef SYNTHESIS
	a_stall_only_on_full_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |-> out_vld_q && !pooled_ready && emit_s1)
		else $error("s1 stalled without a blocked result");

	a_emit_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && emit_s1 |=> pooled_valid && pooled == $past(result_s1))
		else $error("window result not loaded into output register");

	a_no_result_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv_s1 && emit_s1) && !(pooled_valid && !pooled_ready) |=> !pooled_valid)
		else $error("result without a completed window");
`endif

endmodule
